// ===== rtl/bpfl_pkg.sv =====
// Shared types and constants of the Blinn-Phong fragment lighting block.
`default_nettype none

package bpfl_pkg;

  // Coordinate width, Q7.8 by default
  localparam int COORD_WIDTH = 16;

  // Fixed widths of the packed fields
  localparam int PACK_W  = 3 * COORD_WIDTH;
  localparam int COLOR_W = 24;
  localparam int SLOT_W  = 3;

  // Normalize unit number formats
  localparam int VEC_W     = 22;  // signed input component, holds any coordinate difference
  localparam int MAG_W     = 21;  // magnitude after the shift to at least 2^20
  localparam int LEN_W     = 44;  // sum of three squared magnitudes
  localparam int ROOT_W    = 22;  // integer square root of that sum
  localparam int QUO_W     = 15;  // unit component magnitude, at most 16384
  localparam int UNIT_W    = 16;  // signed Q1.14 unit component
  localparam int FRAC      = 14;
  localparam int UNIT_ONE  = 16384;

  // Color constants and final scaling
  localparam logic [7:0] GRAY  = 8'd153;
  localparam logic [7:0] WHITE = 8'd255;
  localparam int ROUND_HALF = 255 * 8192;
  localparam int SAT_LIMIT  = 255 * 256;

  // Operation codes
  localparam logic OP_SHADE = 1'b0;
  localparam logic OP_LOAD  = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] REG_EYE       = 3'd0;
  localparam logic [2:0] REG_SHININESS = 3'd1;
  localparam logic [2:0] REG_COUNT     = 3'd2;
  localparam logic [2:0] REG_DIFF_TEX  = 3'd3;
  localparam logic [2:0] REG_SPEC_TEX  = 3'd4;

  typedef logic signed [VEC_W-1:0]  ncomp_t;
  typedef logic signed [UNIT_W-1:0] ucomp_t;

  // One light slot as stored
  typedef struct packed {
    logic                 is_point;
    logic [PACK_W-1:0]    vector;
    logic [COLOR_W-1:0]   ambient;
    logic [COLOR_W-1:0]   diffuse;
    logic [COLOR_W-1:0]   specular;
  } light_t;

  // One classified item in the queue between front and back
  typedef struct packed {
    logic                 is_load;
    logic [SLOT_W-1:0]    slot;
    logic [PACK_W-1:0]    normal;
    logic [PACK_W-1:0]    position;
    logic [COLOR_W-1:0]   diffuse_texel;
    logic [COLOR_W-1:0]   specular_texel;
    light_t               light;
  } item_t;

endpackage

`default_nettype wire

// ===== rtl/blinn_phong_fragment_lighting_top.sv =====
// Top level of the Blinn-Phong fragment lighting block: config registers, front, back.
//
//   channel   handshake                 payload
//   input     start / busy              operation, normal .. light_specular_rgb
//   result    done (one-cycle strobe)   red, green, blue
//   config    write_enable              write_index, write_data
//
// A load is queued and then written to its slot. A shade normalizes the normal and the
// view vector, then for each light the light and half vectors; one pass of the
// normalize unit is start, shift search, three squares, 22 root steps, 15 divide
// steps and the done cycle. The shared multiplier forms the dot products, the
// specular power and the color sums.
// Reset is synchronous; the light store is not cleared. The queue takes up to two
// items while the back end works; busy rises when it is full. Results cannot stall.
`default_nettype none

module blinn_phong_fragment_lighting_top #(
  parameter int MAX_LIGHTS  = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          operation,
  input  logic [bpfl_pkg::PACK_W-1:0]   normal_xyz,
  input  logic [bpfl_pkg::PACK_W-1:0]   position_xyz,
  input  logic [bpfl_pkg::COLOR_W-1:0]  diffuse_texel_rgb,
  input  logic [bpfl_pkg::COLOR_W-1:0]  specular_texel_rgb,
  input  logic [bpfl_pkg::SLOT_W-1:0]   light_slot,
  input  logic [bpfl_pkg::PACK_W-1:0]   light_vector_xyz,
  input  logic                          light_is_point,
  input  logic [bpfl_pkg::COLOR_W-1:0]  light_ambient_rgb,
  input  logic [bpfl_pkg::COLOR_W-1:0]  light_diffuse_rgb,
  input  logic [bpfl_pkg::COLOR_W-1:0]  light_specular_rgb,
  input  logic                          write_enable,
  input  logic [2:0]                    write_index,
  input  logic [bpfl_pkg::PACK_W-1:0]   write_data,
  output logic                          done,
  output logic [7:0]                    red,
  output logic [7:0]                    green,
  output logic [7:0]                    blue
);
  import bpfl_pkg::*;

  logic [PACK_W-1:0] eye_position;
  logic [7:0]        shininess;
  logic [3:0]        light_count;
  logic              diffuse_sel;
  logic              specular_sel;
  logic              q_valid;
  logic              q_ready;
  item_t             q_item;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      eye_position <= '0;
      shininess    <= 8'd32;
      light_count  <= 4'd0;
      diffuse_sel  <= 1'b0;
      specular_sel <= 1'b0;
    end else if (write_enable) begin
      unique case (write_index)
        REG_EYE:       eye_position <= write_data;
        REG_SHININESS: shininess    <= write_data[7:0];
        REG_COUNT:     light_count  <= write_data[3:0];
        REG_DIFF_TEX:  diffuse_sel  <= write_data[0];
        REG_SPEC_TEX:  specular_sel <= write_data[0];
        default: ;
      endcase
    end
  end

  bpfl_front #(
    .MAX_LIGHTS (MAX_LIGHTS)
  ) u_front (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .busy               (busy),
    .operation          (operation),
    .normal_xyz         (normal_xyz),
    .position_xyz       (position_xyz),
    .diffuse_texel_rgb  (diffuse_texel_rgb),
    .specular_texel_rgb (specular_texel_rgb),
    .light_slot         (light_slot),
    .light_vector_xyz   (light_vector_xyz),
    .light_is_point     (light_is_point),
    .light_ambient_rgb  (light_ambient_rgb),
    .light_diffuse_rgb  (light_diffuse_rgb),
    .light_specular_rgb (light_specular_rgb),
    .pop_valid          (q_valid),
    .pop_item           (q_item),
    .pop_ready          (q_ready)
  );

  bpfl_back #(
    .MAX_LIGHTS  (MAX_LIGHTS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_ready      (q_ready),
    .eye_position (eye_position),
    .shininess    (shininess),
    .light_count  (light_count),
    .diffuse_sel  (diffuse_sel),
    .specular_sel (specular_sel),
    .done         (done),
    .red          (red),
    .green        (green),
    .blue         (blue)
  );

endmodule

`default_nettype wire

// ===== rtl/bpfl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bpfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, register the read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/bpfl_front.sv =====
// Front end: accepts items, classifies them and queues them for the back end.
`default_nettype none

module bpfl_front #(
  parameter int MAX_LIGHTS = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            operation,
  input  logic [bpfl_pkg::PACK_W-1:0]     normal_xyz,
  input  logic [bpfl_pkg::PACK_W-1:0]     position_xyz,
  input  logic [bpfl_pkg::COLOR_W-1:0]    diffuse_texel_rgb,
  input  logic [bpfl_pkg::COLOR_W-1:0]    specular_texel_rgb,
  input  logic [bpfl_pkg::SLOT_W-1:0]     light_slot,
  input  logic [bpfl_pkg::PACK_W-1:0]     light_vector_xyz,
  input  logic                            light_is_point,
  input  logic [bpfl_pkg::COLOR_W-1:0]    light_ambient_rgb,
  input  logic [bpfl_pkg::COLOR_W-1:0]    light_diffuse_rgb,
  input  logic [bpfl_pkg::COLOR_W-1:0]    light_specular_rgb,
  output logic                            pop_valid,
  output bpfl_pkg::item_t                 pop_item,
  input  logic                            pop_ready
);
  import bpfl_pkg::*;

  item_t      entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  item_t      item_in;
  logic       accept;
  logic       push;
  logic       pop;

  // Classify the incoming item; a load to a missing slot is dropped here
  always_comb begin
    item_in.is_load        = (operation == OP_LOAD);
    item_in.slot           = light_slot;
    item_in.normal         = normal_xyz;
    item_in.position       = position_xyz;
    item_in.diffuse_texel  = diffuse_texel_rgb;
    item_in.specular_texel = specular_texel_rgb;
    item_in.light.is_point = light_is_point;
    item_in.light.vector   = light_vector_xyz;
    item_in.light.ambient  = light_ambient_rgb;
    item_in.light.diffuse  = light_diffuse_rgb;
    item_in.light.specular = light_specular_rgb;
  end

  assign busy      = count[1];
  assign accept    = start && !busy;
  assign push      = accept && !(item_in.is_load && (32'(light_slot) >= MAX_LIGHTS));
  assign pop_valid = (count != 2'd0);
  assign pop_item  = entry[rd_ptr];
  assign pop       = pop_valid && pop_ready;

  // Hold queued items
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= item_in;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bpfl_norm.sv =====
// Normalize unit: shift, sum of squares, bit-serial square root, three-lane divide.
`default_nettype none

module bpfl_norm (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  bpfl_pkg::ncomp_t vin [3],
  output logic             done,
  output bpfl_pkg::ucomp_t vout [3]
);
  import bpfl_pkg::*;

  typedef enum logic [2:0] {
    N_IDLE,
    N_SHIFT,
    N_SQUARE,
    N_ROOT,
    N_DIV
  } nstate_t;

  nstate_t            state;
  logic [MAG_W-1:0]   mag [3];
  logic               neg [3];
  logic [MAG_W-1:0]   mmax;
  logic [1:0]         j;
  logic [LEN_W-1:0]   len2;
  logic [2*MAG_W-1:0] sq;
  logic [LEN_W-1:0]   rx;
  logic [LEN_W:0]     root;
  logic [LEN_W-1:0]   rbit;
  logic [LEN_W:0]     trial;
  logic               take;
  logic [LEN_W:0]     root_next;
  logic [ROOT_W-1:0]  s;
  logic [ROOT_W:0]    rem [3];
  logic [QUO_W-1:0]   quo [3];
  logic [3:0]         cnt;
  logic [ROOT_W:0]    sh [3];
  logic               qbit [3];

  // Largest magnitude and the current square
  always_comb begin
    mmax = mag[0];
    if (mag[1] > mmax) begin
      mmax = mag[1];
    end
    if (mag[2] > mmax) begin
      mmax = mag[2];
    end
    sq = mag[j] * mag[j];
  end

  // One square root step
  always_comb begin
    trial     = root + {1'b0, rbit};
    take      = ({1'b0, rx} >= trial);
    root_next = take ? ((root >> 1) + {1'b0, rbit}) : (root >> 1);
  end

  // One restoring divide step in each lane
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh[i]   = {rem[i][ROOT_W-1:0], (cnt == 4'(QUO_W - 1)) ? mag[i][0] : 1'b0};
      qbit[i] = (sh[i] >= {1'b0, s});
    end
  end

  // Sequence one normalization
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        N_IDLE: begin
          if (start) begin
            for (int i = 0; i < 3; i++) begin
              neg[i] <= vin[i][VEC_W-1];
              mag[i] <= MAG_W'(vin[i][VEC_W-1] ? -vin[i] : vin[i]);
            end
            state <= N_SHIFT;
          end
        end
        N_SHIFT: begin
          if (mmax == '0) begin
            for (int i = 0; i < 3; i++) begin
              vout[i] <= '0;
            end
            done  <= 1'b1;
            state <= N_IDLE;
          end else if (!mmax[MAG_W-1]) begin
            for (int i = 0; i < 3; i++) begin
              mag[i] <= mag[i] << 1;
            end
          end else begin
            len2  <= '0;
            j     <= 2'd0;
            state <= N_SQUARE;
          end
        end
        N_SQUARE: begin
          len2 <= len2 + LEN_W'(sq);
          j    <= j + 2'd1;
          if (j == 2'd2) begin
            rx    <= len2 + LEN_W'(sq);
            root  <= '0;
            rbit  <= LEN_W'(1) << (LEN_W - 2);
            state <= N_ROOT;
          end
        end
        N_ROOT: begin
          if (take) begin
            rx <= rx - trial[LEN_W-1:0];
          end
          root <= root_next;
          rbit <= rbit >> 2;
          if (rbit[0]) begin
            s <= root_next[ROOT_W-1:0];
            for (int i = 0; i < 3; i++) begin
              rem[i] <= (ROOT_W + 1)'(mag[i] >> 1);
              quo[i] <= '0;
            end
            cnt   <= 4'(QUO_W - 1);
            state <= N_DIV;
          end
        end
        N_DIV: begin
          for (int i = 0; i < 3; i++) begin
            rem[i] <= qbit[i] ? (sh[i] - {1'b0, s}) : sh[i];
            quo[i] <= {quo[i][QUO_W-2:0], qbit[i]};
          end
          cnt <= cnt - 4'd1;
          if (cnt == 4'd0) begin
            for (int i = 0; i < 3; i++) begin
              vout[i] <= neg[i] ? -UNIT_W'({quo[i][QUO_W-2:0], qbit[i]})
                                :  UNIT_W'({quo[i][QUO_W-2:0], qbit[i]});
            end
            done  <= 1'b1;
            state <= N_IDLE;
          end
        end
        default: state <= N_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bpfl_back.sv =====
// Back end: light store, per-light sequencer with a shared multiplier, color sums.
`default_nettype none

module bpfl_back #(
  parameter int MAX_LIGHTS  = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  bpfl_pkg::item_t               q_item,
  output logic                          q_ready,
  input  logic [bpfl_pkg::PACK_W-1:0]   eye_position,
  input  logic [7:0]                    shininess,
  input  logic [3:0]                    light_count,
  input  logic                          diffuse_sel,
  input  logic                          specular_sel,
  output logic                          done,
  output logic [7:0]                    red,
  output logic [7:0]                    green,
  output logic [7:0]                    blue
);
  import bpfl_pkg::*;

  localparam int AW     = MAX_LIGHTS > 1 ? $clog2(MAX_LIGHTS) : 1;
  localparam int LCNT_W = $clog2(MAX_LIGHTS + 1);
  localparam int PK_W   = 3 * COORD_WIDTH;
  localparam int ACC_W  = 33 + $clog2(MAX_LIGHTS);
  localparam int MUL_W  = 17;
  localparam int DOT_W  = 32;
  localparam int Y_W    = ACC_W - FRAC;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM_N,
    ST_NORM_V,
    ST_READ,
    ST_LIGHT,
    ST_NORM_L,
    ST_NORM_H,
    ST_DOT_L,
    ST_DOT_H,
    ST_POW,
    ST_COLOR,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    CS_AMB,
    CS_DIF_K,
    CS_DIF,
    CS_SPE_K,
    CS_SPE
  } cstep_t;

  state_t                  state;
  cstep_t                  cstep;
  logic [PACK_W-1:0]       pos_r;
  logic [COLOR_W-1:0]      dtex_r;
  logic [COLOR_W-1:0]      stex_r;
  ucomp_t                  n [3];
  ucomp_t                  v [3];
  ucomp_t                  l [3];
  ucomp_t                  h [3];
  ncomp_t                  norm_in [3];
  logic                    norm_start;
  logic                    norm_done;
  ucomp_t                  norm_out [3];
  logic [LCNT_W-1:0]       k;
  logic [LCNT_W-1:0]       cnt;
  logic [1:0]              j;
  logic [1:0]              ch;
  logic signed [DOT_W-1:0] dot_acc;
  logic signed [DOT_W-1:0] dot_sum;
  logic [QUO_W-1:0]        ndotl;
  logic [QUO_W-1:0]        ndoth;
  logic [QUO_W-1:0]        pw;
  logic [2:0]              pw_bit;
  logic                    pw_phase;
  logic [15:0]             t;
  logic [ACC_W-1:0]        acc [3];
  logic [7:0]              kd;
  logic [7:0]              ks;
  logic [7:0]              la;
  logic [7:0]              ld;
  logic [7:0]              ls;
  logic signed [MUL_W-1:0] mul_a;
  logic signed [MUL_W-1:0] mul_b;
  logic signed [2*MUL_W-1:0] mul_y;
  logic                    ram_we;
  light_t                  rdata;
  logic [7:0]              chan [3];
  logic [ACC_W-1:0]        xs [3];
  logic [Y_W-1:0]          ys [3];
  logic [16:0]             qs [3];

  // Signed coordinate c of a packed vector, widened for differences
  function automatic ncomp_t coord(input logic [PACK_W-1:0] p, input int c);
    logic [PK_W-1:0] pk;
    pk = PK_W'(p);
    return VEC_W'($signed(pk[c*COORD_WIDTH +: COORD_WIDTH]));
  endfunction

  // Dot product clamp to [0, 1.0] in Q1.14
  function automatic logic [QUO_W-1:0] clamp_dot(input logic signed [DOT_W-1:0] sum);
    logic signed [DOT_W-1:0] d;
    d = sum >>> FRAC;
    if (sum <= 0) begin
      return '0;
    end else if (d > UNIT_ONE) begin
      return QUO_W'(UNIT_ONE);
    end else begin
      return d[QUO_W-1:0];
    end
  endfunction

  bpfl_ram #(
    .WIDTH ($bits(light_t)),
    .DEPTH (MAX_LIGHTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(q_item.slot)),
    .wdata (q_item.light),
    .raddr (k[AW-1:0]),
    .rdata (rdata)
  );

  bpfl_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (norm_start),
    .vin   (norm_in),
    .done  (norm_done),
    .vout  (norm_out)
  );

  assign q_ready = (state == ST_IDLE);
  assign ram_we  = (state == ST_IDLE) && q_valid && q_item.is_load;
  assign cnt     = (32'(light_count) > MAX_LIGHTS) ? LCNT_W'(MAX_LIGHTS)
                                                   : LCNT_W'(light_count);

  // Material and light channel selection
  always_comb begin
    kd = diffuse_sel  ? dtex_r[ch*8 +: 8] : GRAY;
    ks = specular_sel ? stex_r[ch*8 +: 8] : WHITE;
    la = rdata.ambient[ch*8 +: 8];
    ld = rdata.diffuse[ch*8 +: 8];
    ls = rdata.specular[ch*8 +: 8];
  end

  // Shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_DOT_L: begin
        mul_a = MUL_W'(n[j]);
        mul_b = MUL_W'(l[j]);
      end
      ST_DOT_H: begin
        mul_a = MUL_W'(n[j]);
        mul_b = MUL_W'(h[j]);
      end
      ST_POW: begin
        mul_a = MUL_W'(pw);
        mul_b = pw_phase ? MUL_W'(ndoth) : MUL_W'(pw);
      end
      ST_COLOR: begin
        unique case (cstep)
          CS_AMB: begin
            mul_a = MUL_W'(la);
            mul_b = MUL_W'(kd);
          end
          CS_DIF_K: begin
            mul_a = MUL_W'(ld);
            mul_b = MUL_W'(kd);
          end
          CS_DIF: begin
            mul_a = MUL_W'(t);
            mul_b = MUL_W'(ndotl);
          end
          CS_SPE_K: begin
            mul_a = MUL_W'(ls);
            mul_b = MUL_W'(ks);
          end
          CS_SPE: begin
            mul_a = MUL_W'(t);
            mul_b = MUL_W'(pw);
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_y   = mul_a * mul_b;
    dot_sum = dot_acc + DOT_W'(mul_y);
  end

  // Round, scale by 1/(255*16384) and saturate each channel
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xs[i] = acc[i] + ACC_W'(ROUND_HALF);
      ys[i] = xs[i][ACC_W-1:FRAC];
      qs[i] = {1'b0, ys[i][15:0]} + 17'(ys[i][15:8]) + 17'd1;
      chan[i] = (ys[i] >= Y_W'(SAT_LIMIT)) ? 8'd255 : qs[i][15:8];
    end
  end

  // Sequence loads and shades
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      done       <= 1'b0;
      norm_start <= 1'b0;
    end else begin
      done       <= 1'b0;
      norm_start <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (q_valid && !q_item.is_load) begin
            pos_r  <= q_item.position;
            dtex_r <= q_item.diffuse_texel;
            stex_r <= q_item.specular_texel;
            for (int c = 0; c < 3; c++) begin
              norm_in[c] <= coord(q_item.normal, c);
              acc[c]     <= '0;
            end
            norm_start <= 1'b1;
            state      <= ST_NORM_N;
          end
        end
        ST_NORM_N: begin
          if (norm_done) begin
            for (int c = 0; c < 3; c++) begin
              n[c]       <= norm_out[c];
              norm_in[c] <= coord(eye_position, c) - coord(pos_r, c);
            end
            norm_start <= 1'b1;
            state      <= ST_NORM_V;
          end
        end
        ST_NORM_V: begin
          if (norm_done) begin
            for (int c = 0; c < 3; c++) begin
              v[c] <= norm_out[c];
            end
            k     <= '0;
            state <= (cnt == '0) ? ST_OUT : ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_LIGHT;
        end
        ST_LIGHT: begin
          for (int c = 0; c < 3; c++) begin
            norm_in[c] <= rdata.is_point ? (coord(rdata.vector, c) - coord(pos_r, c))
                                         : -coord(rdata.vector, c);
          end
          norm_start <= 1'b1;
          state      <= ST_NORM_L;
        end
        ST_NORM_L: begin
          if (norm_done) begin
            for (int c = 0; c < 3; c++) begin
              l[c]       <= norm_out[c];
              norm_in[c] <= VEC_W'(v[c]) + VEC_W'(norm_out[c]);
            end
            norm_start <= 1'b1;
            state      <= ST_NORM_H;
          end
        end
        ST_NORM_H: begin
          if (norm_done) begin
            for (int c = 0; c < 3; c++) begin
              h[c] <= norm_out[c];
            end
            j       <= 2'd0;
            dot_acc <= '0;
            state   <= ST_DOT_L;
          end
        end
        ST_DOT_L: begin
          dot_acc <= dot_sum;
          j       <= j + 2'd1;
          if (j == 2'd2) begin
            ndotl   <= clamp_dot(dot_sum);
            dot_acc <= '0;
            j       <= 2'd0;
            state   <= ST_DOT_H;
          end
        end
        ST_DOT_H: begin
          dot_acc <= dot_sum;
          j       <= j + 2'd1;
          if (j == 2'd2) begin
            ndoth    <= clamp_dot(dot_sum);
            pw       <= QUO_W'(UNIT_ONE);
            pw_bit   <= 3'd7;
            pw_phase <= 1'b0;
            state    <= ST_POW;
          end
        end
        ST_POW: begin
          pw <= mul_y[FRAC +: QUO_W];
          if (!pw_phase && shininess[pw_bit]) begin
            pw_phase <= 1'b1;
          end else begin
            pw_phase <= 1'b0;
            pw_bit   <= pw_bit - 3'd1;
            if (pw_bit == 3'd0) begin
              ch    <= 2'd0;
              cstep <= CS_AMB;
              state <= ST_COLOR;
            end
          end
        end
        ST_COLOR: begin
          unique case (cstep)
            CS_AMB: begin
              acc[ch] <= acc[ch] + (ACC_W'(mul_y[15:0]) << FRAC);
              cstep   <= CS_DIF_K;
            end
            CS_DIF_K: begin
              t     <= mul_y[15:0];
              cstep <= CS_DIF;
            end
            CS_DIF: begin
              acc[ch] <= acc[ch] + ACC_W'(mul_y[30:0]);
              cstep   <= CS_SPE_K;
            end
            CS_SPE_K: begin
              t     <= mul_y[15:0];
              cstep <= CS_SPE;
            end
            CS_SPE: begin
              acc[ch] <= acc[ch] + ACC_W'(mul_y[30:0]);
              cstep   <= CS_AMB;
              if (ch == 2'd2) begin
                k <= k + 1'b1;
                state <= ((k + 1'b1) == cnt) ? ST_OUT : ST_READ;
              end else begin
                ch <= ch + 2'd1;
              end
            end
            default: cstep <= CS_AMB;
          endcase
        end
        ST_OUT: begin
          red   <= chan[0];
          green <= chan[1];
          blue  <= chan[2];
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bpfl_checker.sv =====
// Port-level checks of the lighting block and their bind to the top level.
`default_nettype none

module bpfl_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // Reset empties the queue
  a_busy_after_reset: assert property (@(posedge clk) rst |=> !busy)
    else $error("busy high after reset");

  // Reset drops any pending result
  a_done_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  // A shade passes through the normalize unit before its result, so results never come back to back
  a_done_strobe: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  // The queue fills only through a transfer on the input side
  a_busy_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && !busy))
    else $error("busy rose without an input transfer");

endmodule

bind blinn_phong_fragment_lighting_top bpfl_checker u_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the Blinn-Phong fragment lighting block.
`default_nettype none

module testbench;
  import bpfl_pkg::*;

  localparam int LIGHTS = 8;
  localparam int CW     = 16;

  typedef longint vec_t[3];

  typedef struct {
    logic                op;
    logic [PACK_W-1:0]   normal;
    logic [PACK_W-1:0]   position;
    logic [COLOR_W-1:0]  dtex;
    logic [COLOR_W-1:0]  stex;
    logic [SLOT_W-1:0]   slot;
    logic [PACK_W-1:0]   lvec;
    logic                is_point;
    logic [COLOR_W-1:0]  amb;
    logic [COLOR_W-1:0]  dif;
    logic [COLOR_W-1:0]  spc;
  } frag_item_t;

  // Shading predictor and queue of expected colors
  class shade_scoreboard;
    logic [PACK_W-1:0]  eye;
    logic [7:0]         shine;
    logic [3:0]         nlights;
    logic               diff_tex;
    logic               spec_tex;
    logic [PACK_W-1:0]  st_vec[LIGHTS];
    logic               st_point[LIGHTS];
    logic [COLOR_W-1:0] st_amb[LIGHTS];
    logic [COLOR_W-1:0] st_dif[LIGHTS];
    logic [COLOR_W-1:0] st_spc[LIGHTS];
    logic [23:0]        pending_rgb[$];
    int                 errors;
    int                 shades;
    int                 loads;

    function new();
      eye = '0; shine = 8'd32; nlights = '0; diff_tex = 0; spec_tex = 0;
      errors = 0; shades = 0; loads = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [PACK_W-1:0] val);
      case (idx)
        REG_EYE:       eye = val;
        REG_SHININESS: shine = val[7:0];
        REG_COUNT:     nlights = val[3:0];
        REG_DIFF_TEX:  diff_tex = val[0];
        REG_SPEC_TEX:  spec_tex = val[0];
        default: ;
      endcase
    endfunction

    function void unpack(logic [PACK_W-1:0] p, output vec_t v);
      for (int i = 0; i < 3; i++) v[i] = longint'($signed(p[i*CW +: CW]));
    endfunction

    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned root, b;
      root = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= root + b) begin
          x -= root + b;
          root = (root >> 1) + b;
        end else begin
          root >>= 1;
        end
        b >>= 2;
      end
      return root;
    endfunction

    // Scale up to at least 2^20, then divide by the integer length
    function void unit_vec(input vec_t v, output vec_t r);
      longint unsigned mag[3];
      longint unsigned m, len2, s, u;
      m = 0; len2 = 0;
      for (int i = 0; i < 3; i++) begin
        mag[i] = v[i] < 0 ? -v[i] : v[i];
        if (mag[i] > m) m = mag[i];
      end
      if (m == 0) begin
        for (int i = 0; i < 3; i++) r[i] = 0;
        return;
      end
      while (m < (64'd1 << 20)) begin
        m <<= 1;
        for (int i = 0; i < 3; i++) mag[i] <<= 1;
      end
      for (int i = 0; i < 3; i++) len2 += mag[i] * mag[i];
      s = int_sqrt(len2);
      for (int i = 0; i < 3; i++) begin
        u = (mag[i] << 14) / s;
        r[i] = v[i] < 0 ? -longint'(u) : longint'(u);
      end
    endfunction

    function longint clamp_dot(vec_t a, vec_t b);
      longint sum;
      sum = a[0]*b[0] + a[1]*b[1] + a[2]*b[2];
      if (sum <= 0) return 0;
      sum = sum >>> 14;
      return sum > UNIT_ONE ? UNIT_ONE : sum;
    endfunction

    function longint spec_power(longint base, logic [7:0] e);
      longint p;
      p = UNIT_ONE;
      for (int b = 7; b >= 0; b--) begin
        p = (p * p) >>> 14;
        if (e[b]) p = (p * base) >>> 14;
      end
      return p;
    endfunction

    function logic [23:0] shade_color(frag_item_t it);
      vec_t pos, eyev, n, view, lv, ldir, half;
      longint acc[3];
      longint ndotl, ndoth, sp, kd, ks, v;
      int cnt;
      logic [23:0] rgb;
      unpack(it.position, pos);
      unpack(eye, eyev);
      unpack(it.normal, n);
      unit_vec(n, n);
      for (int i = 0; i < 3; i++) view[i] = eyev[i] - pos[i];
      unit_vec(view, view);
      for (int i = 0; i < 3; i++) acc[i] = 0;
      cnt = nlights > LIGHTS ? LIGHTS : nlights;
      for (int k = 0; k < cnt; k++) begin
        unpack(st_vec[k], lv);
        for (int i = 0; i < 3; i++) lv[i] = st_point[k] ? lv[i] - pos[i] : -lv[i];
        unit_vec(lv, ldir);
        for (int i = 0; i < 3; i++) half[i] = view[i] + ldir[i];
        unit_vec(half, half);
        ndotl = clamp_dot(n, ldir);
        ndoth = clamp_dot(n, half);
        sp = spec_power(ndoth, shine);
        for (int i = 0; i < 3; i++) begin
          kd = diff_tex ? it.dtex[8*i +: 8] : GRAY;
          ks = spec_tex ? it.stex[8*i +: 8] : WHITE;
          acc[i] += st_amb[k][8*i +: 8] * kd * UNIT_ONE;
          acc[i] += st_dif[k][8*i +: 8] * kd * ndotl;
          acc[i] += st_spc[k][8*i +: 8] * ks * sp;
        end
      end
      for (int i = 0; i < 3; i++) begin
        v = (acc[i] + 255 * 8192) / (255 * UNIT_ONE);
        rgb[8*i +: 8] = v > 255 ? 8'd255 : v[7:0];
      end
      return rgb;
    endfunction

    // Apply one accepted transfer: store a light or queue a color
    function void note_input(frag_item_t it);
      if (it.op == OP_LOAD) begin
        st_vec[it.slot] = it.lvec;
        st_point[it.slot] = it.is_point;
        st_amb[it.slot] = it.amb;
        st_dif[it.slot] = it.dif;
        st_spc[it.slot] = it.spc;
        loads++;
      end else begin
        pending_rgb.push_back(shade_color(it));
        shades++;
      end
    endfunction

    task report(string what);
      $display("ERROR at %0t: %s", $time, what);
      errors++;
    endtask

    task check_result(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      logic [23:0] want;
      if (pending_rgb.size() == 0) begin
        report($sformatf("unexpected color %0d %0d %0d", r, g, b));
        return;
      end
      want = pending_rgb.pop_front();
      if (r !== want[7:0])
        report($sformatf("red %0d, want %0d", r, want[7:0]));
      if (g !== want[15:8])
        report($sformatf("green %0d, want %0d", g, want[15:8]));
      if (b !== want[23:16])
        report($sformatf("blue %0d, want %0d", b, want[23:16]));
    endtask
  endclass

  logic                clk = 0;
  logic                rst = 1;
  logic                start = 0;
  logic                busy;
  logic                operation = OP_SHADE;
  logic [PACK_W-1:0]   normal_xyz = '0;
  logic [PACK_W-1:0]   position_xyz = '0;
  logic [COLOR_W-1:0]  diffuse_texel_rgb = '0;
  logic [COLOR_W-1:0]  specular_texel_rgb = '0;
  logic [SLOT_W-1:0]   light_slot = '0;
  logic [PACK_W-1:0]   light_vector_xyz = '0;
  logic                light_is_point = 0;
  logic [COLOR_W-1:0]  light_ambient_rgb = '0;
  logic [COLOR_W-1:0]  light_diffuse_rgb = '0;
  logic [COLOR_W-1:0]  light_specular_rgb = '0;
  logic                write_enable = 0;
  logic [2:0]          write_index = '0;
  logic [PACK_W-1:0]   write_data = '0;
  logic                done;
  logic [7:0]          red, green, blue;

  shade_scoreboard sb = new();

  blinn_phong_fragment_lighting_top DUT (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // Results cannot be held off: check every strobe
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(red, green, blue);
  end

  initial begin
    #200_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [PACK_W-1:0] rand_vec();
    logic [PACK_W-1:0] v;
    int mode;
    mode = $urandom_range(0, 9);
    v = PACK_W'({$urandom(), $urandom()});
    if (mode == 0) v = '0;
    else if (mode < 5)
      for (int i = 0; i < 3; i++) v[i*CW +: CW] = 16'($signed($urandom_range(0, 8192)) - 4096);
    return v;
  endfunction

  function automatic logic [COLOR_W-1:0] rand_color();
    int mode;
    mode = $urandom_range(0, 9);
    if (mode == 0) return '0;
    if (mode == 1) return '1;
    return 24'($urandom());
  endfunction

  function automatic frag_item_t rand_item();
    frag_item_t it;
    it.op = ($urandom_range(0, 6) == 0) ? OP_LOAD : OP_SHADE;
    it.normal = rand_vec();
    it.position = ($urandom_range(0, 15) == 0) ? sb.eye : rand_vec();
    it.dtex = rand_color();
    it.stex = rand_color();
    it.slot = 3'($urandom_range(0, 7));
    it.lvec = rand_vec();
    it.is_point = 1'($urandom_range(0, 1));
    it.amb = rand_color();
    it.dif = rand_color();
    it.spc = rand_color();
    return it;
  endfunction

  // Drive one item after a random gap and hold it until transferred
  task automatic send(frag_item_t it);
    int gap;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    operation <= it.op;
    normal_xyz <= it.normal;
    position_xyz <= it.position;
    diffuse_texel_rgb <= it.dtex;
    specular_texel_rgb <= it.stex;
    light_slot <= it.slot;
    light_vector_xyz <= it.lvec;
    light_is_point <= it.is_point;
    light_ambient_rgb <= it.amb;
    light_diffuse_rgb <= it.dif;
    light_specular_rgb <= it.spc;
    do @(posedge clk); while (busy);
    sb.note_input(it);
  endtask

  // Wait for every color, then let a trailing load settle
  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (sb.pending_rgb.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_regs(logic [PACK_W-1:0] eye, logic [7:0] shine, logic [3:0] cnt,
                            logic dtex, logic stex);
    logic [PACK_W-1:0] vals[5];
    logic [2:0] idx[5];
    vals = '{eye, PACK_W'(shine), PACK_W'(cnt), PACK_W'(dtex), PACK_W'(stex)};
    idx = '{REG_EYE, REG_SHININESS, REG_COUNT, REG_DIFF_TEX, REG_SPEC_TEX};
    for (int i = 0; i < 5; i++) begin
      write_enable <= 1;
      write_index <= idx[i];
      write_data <= vals[i];
      @(posedge clk);
      sb.set_reg(idx[i], vals[i]);
    end
    write_enable <= 0;
  endtask

  initial begin
    frag_item_t it;
    logic [PACK_W-1:0] eye;
    logic [7:0] shine;
    logic [3:0] cnt;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: shade with no lights, then fill every slot
    it = rand_item();
    it.op = OP_SHADE;
    send(it);
    for (int s = 0; s < LIGHTS; s++) begin
      it = rand_item();
      it.op = OP_LOAD;
      it.slot = 3'(s);
      it.is_point = s[0];
      it.amb = (s == 2) ? '1 : (s == 3) ? '0 : it.amb;
      it.dif = (s == 2) ? '1 : it.dif;
      it.spc = (s == 2) ? '1 : (s == 3) ? '0 : it.spc;
      it.lvec = (s < 2) ? '0 : (s == 4) ? 48'h8000_8000_8000
              : (s == 5) ? 48'h7FFF_7FFF_7FFF : it.lvec;
      send(it);
    end
    drain();

    // Directed: zero exponent, oversized count, textures on
    write_regs(48'h0000_0000_0100, 8'd0, 4'd15, 1'b1, 1'b1);
    for (int d = 0; d < 8; d++) begin
      it = rand_item();
      it.op = OP_SHADE;
      case (d)
        0: it.normal = '0;
        1: it.position = sb.eye;
        2: it.normal = 48'h7FFF_7FFF_7FFF;
        3: it.normal = 48'h8000_8000_8000;
        4: it.position = sb.st_vec[1];
        5: begin it.dtex = '1; it.stex = '1; end
        6: begin it.dtex = '0; it.stex = '0; end
        default: it.position = 48'h7FFF_8000_7FFF;
      endcase
      send(it);
    end
    drain();

    // Random phases, each under its own register setting
    for (int p = 0; p < 8; p++) begin
      eye = PACK_W'({$urandom(), $urandom()});
      shine = 8'($urandom_range(1, 255));
      cnt = 4'($urandom_range(0, 8));
      case (p)
        0: begin eye = '0; shine = 8'd1; cnt = 4'd8; end
        1: begin eye = '1; shine = 8'd255; cnt = 4'd1; end
        2: begin eye = 48'h7FFF_8000_7FFF; cnt = 4'd0; end
        3: begin eye = 48'h8000_7FFF_8000; cnt = 4'd15; end
        4: shine = 8'd0;
        default: ;
      endcase
      write_regs(eye, shine, cnt, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      for (int n = 0; n < 120; n++) send(rand_item());
      drain();
    end

    repeat (100) @(posedge clk);
    $display("Covered %0d shaded fragments and %0d light loads over 10 register settings.",
             sb.shades, sb.loads);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/bpfl_pkg.sv
rtl/bpfl_ram.sv
rtl/bpfl_front.sv
rtl/bpfl_norm.sv
rtl/bpfl_back.sv
rtl/blinn_phong_fragment_lighting_top.sv
rtl/bpfl_checker.sv
dv/testbench.sv
